@@ hdl/key_value_table_core_defines.svh @@
// assertion macros shared by the key value table modules
// expects signals named clock and reset in the module that uses them
`ifndef KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define KEY_VALUE_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define KVT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KVT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/kvt_pkg.sv @@
// types and codes for the key value table
// no dependencies
`default_nettype none

package kvt_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_PRESENT   = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic                      valid;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   // finished request handed from the controller to the response stage
   typedef struct packed {
      logic                      valid;
      status_type                status;
      logic signed [VALUE_W-1:0] found_value;
      logic                      inc;
      logic                      dec;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/kvt_req_if.sv @@
// request channel: opcode, key and value with valid/ready
// uses kvt_pkg for field widths
`default_nettype none

interface kvt_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        opcode;
   logic signed [kvt_pkg::KEY_W-1:0]   lookup_key;
   logic signed [kvt_pkg::VALUE_W-1:0] new_value;

   modport source (output valid, output opcode, output lookup_key, output new_value,
                   input ready);
   modport sink   (input valid, input opcode, input lookup_key, input new_value,
                   output ready);
endinterface

`default_nettype wire

@@ hdl/kvt_rsp_if.sv @@
// response channel: status, value and entry count with valid/ready
// uses kvt_pkg for field widths
`default_nettype none

interface kvt_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic signed [kvt_pkg::VALUE_W-1:0] found_value;
   logic [kvt_pkg::COUNT_W-1:0]        entry_count;

   modport source (output valid, output status, output found_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input found_value, input entry_count,
                   output ready);
endinterface

`default_nettype wire

@@ hdl/key_value_table_core.sv @@
// requests: one at a time; a new request is accepted only after the previous one has been
// written back, following a one-slot-per-cycle scan of the slot memory, which has one
// write port and one read port
// reset: synchronous; a clearing pass marks every slot free, one slot per cycle,
// before the first request is accepted, and the entry count starts at zero
`default_nettype none
`include "key_value_table_core_defines.svh"

module key_value_table_core #(
   parameter int CAPACITY = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   kvt_req_if.sink   req_bus,
   kvt_rsp_if.source rsp_bus
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OW = $clog2(CAPACITY + 1);

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   kvt_pkg::entry_type wr_data;
   kvt_pkg::entry_type rd_data;
   kvt_pkg::result_type res;
   logic               res_ready;
   logic               rsp_load;

   logic [OW-1:0] occ_ff, occ_in;
   logic rsp_valid_ff, rsp_valid_in;
   kvt_pkg::status_type status_ff, status_in;
   logic signed [kvt_pkg::VALUE_W-1:0] found_ff, found_in;
   logic [kvt_pkg::COUNT_W-1:0] count_ff, count_in;

   kvt_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kvt_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res       (res),
      .res_ready (res_ready)
   );

   // response register frees the controller while a response waits
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load  = res.valid && res_ready;

   always_comb begin
      occ_in       = occ_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (rsp_load) begin
         occ_in       = occ_ff + OW'(res.inc) - OW'(res.dec);
         status_in    = res.status;
         found_in     = res.found_value;
         count_in     = kvt_pkg::COUNT_W'(occ_in);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      found_ff  <= found_in;
      count_ff  <= count_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.found_value = found_ff;
   assign rsp_bus.entry_count = count_ff;

   `KVT_ASSERT_IMPL(a_occ_max, 1'b1, occ_ff <= OW'(CAPACITY), "entry count above capacity")
   `KVT_ASSERT_IMPL(a_inc_dec, res.valid, !(res.inc && res.dec), "insert and remove in one result")
   `KVT_ASSERT_IMPL(a_count_match, rsp_valid_ff, count_ff == kvt_pkg::COUNT_W'(occ_ff), "response count differs from occupancy")

endmodule

`default_nettype wire

@@ hdl/kvt_mem.sv @@
// slot memory: one write port, one read port, registered read data
// uses kvt_pkg::entry_type
`default_nettype none

module kvt_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire kvt_pkg::entry_type wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output kvt_pkg::entry_type      rd_data
);

   kvt_pkg::entry_type store_ff [DEPTH];
   kvt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/kvt_ctrl.sv @@
// sequencer: clearing pass, slot scan, write-back
// uses kvt_pkg, kvt_req_if and the assertion macros
`default_nettype none
`include "key_value_table_core_defines.svh"

module kvt_ctrl #(
   parameter int CAPACITY = 16,
   parameter int AW       = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   kvt_req_if.sink            req_bus,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output kvt_pkg::entry_type wr_data,
   output logic [AW-1:0]      rd_addr,
   input  wire kvt_pkg::entry_type rd_data,
   output kvt_pkg::result_type res,
   input  wire logic          res_ready
);

   localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

   kvt_pkg::state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   kvt_pkg::opcode_type op_ff, op_in;
   logic signed [kvt_pkg::KEY_W-1:0] key_ff, key_in;
   logic signed [kvt_pkg::VALUE_W-1:0] val_ff, val_in;
   logic hit_ff, hit_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic signed [kvt_pkg::VALUE_W-1:0] hit_val_ff, hit_val_in;
   logic free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic do_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kvt_pkg::ST_CLEAR;
         idx_ff   <= '0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         hit_ff   <= hit_in;
         free_ff  <= free_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      hit_idx_ff  <= hit_idx_in;
      hit_val_ff  <= hit_val_in;
      free_idx_ff <= free_idx_in;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_val_in  = hit_val_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      req_bus.ready = 1'b0;
      rd_addr     = '0;
      wr_addr     = idx_ff;
      wr_data     = '0;
      do_write    = 1'b0;
      wr_en       = 1'b0;
      res         = '0;
      res.status  = kvt_pkg::STAT_NOT_FOUND;

      case (state_ff)
         kvt_pkg::ST_CLEAR: begin
            // one slot per cycle after reset
            wr_en = 1'b1;
            if (idx_ff == LAST) begin
               idx_in   = '0;
               state_in = kvt_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         kvt_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               op_in    = kvt_pkg::opcode_type'(req_bus.opcode);
               key_in   = req_bus.lookup_key;
               val_in   = req_bus.new_value;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               idx_in   = '0;
               state_in = kvt_pkg::ST_SCAN;
            end
         end
         kvt_pkg::ST_SCAN: begin
            // rd_data holds slot idx_ff, next address already issued
            rd_addr = (idx_ff == LAST) ? '0 : idx_ff + 1'b1;
            if (rd_data.valid && (rd_data.key == key_ff) && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
               hit_val_in = rd_data.value;
            end
            if (!rd_data.valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            if (idx_ff == LAST) begin
               state_in = kvt_pkg::ST_WRITE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         kvt_pkg::ST_WRITE: begin
            res.valid = 1'b1;
            case (op_ff)
               kvt_pkg::OP_INSERT: begin
                  if (hit_ff) begin
                     res.status = kvt_pkg::STAT_PRESENT;
                  end else if (!free_ff) begin
                     res.status = kvt_pkg::STAT_FULL;
                  end else begin
                     res.status    = kvt_pkg::STAT_OK;
                     res.inc       = 1'b1;
                     do_write      = 1'b1;
                     wr_addr       = free_idx_ff;
                     wr_data.valid = 1'b1;
                     wr_data.key   = key_ff;
                     wr_data.value = val_ff;
                  end
               end
               kvt_pkg::OP_LOOKUP: begin
                  if (hit_ff) begin
                     res.status      = kvt_pkg::STAT_OK;
                     res.found_value = hit_val_ff;
                  end
               end
               kvt_pkg::OP_REMOVE: begin
                  if (hit_ff) begin
                     res.status      = kvt_pkg::STAT_OK;
                     res.found_value = hit_val_ff;
                     res.dec         = 1'b1;
                     do_write        = 1'b1;
                     wr_addr         = hit_idx_ff;
                     wr_data.valid   = 1'b0;
                     wr_data.key     = key_ff;
                     wr_data.value   = hit_val_ff;
                  end
               end
               default: begin
                  res.status = kvt_pkg::STAT_NOT_FOUND;
               end
            endcase
            // hold until the response register can take it
            wr_en = do_write && res_ready;
            if (res_ready) begin
               state_in = kvt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kvt_pkg::ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   `KVT_ASSERT_IMPL(a_wr_state, wr_en, (state_ff == kvt_pkg::ST_CLEAR) || (state_ff == kvt_pkg::ST_WRITE), "memory write outside clear or write-back")
   `KVT_ASSERT_NEXT(a_scan_end, (state_ff == kvt_pkg::ST_SCAN) && (idx_ff == LAST), state_ff == kvt_pkg::ST_WRITE, "scan did not end in write-back")
   `KVT_ASSERT_IMPL(a_remove_addr, wr_en && (state_ff == kvt_pkg::ST_WRITE) && !wr_data.valid, hit_ff && (wr_addr == hit_idx_ff), "remove wrote a slot other than the hit")

endmodule

`default_nettype wire

@@ dv/key_value_table_core_checker.sv @@
// response checker for key_value_table_core: tracks the table contents from accepted
// requests and compares every accepted response with the predicted one
// depends on kvt_pkg, kvt_req_if and kvt_rsp_if
module key_value_table_core_checker #(
   parameter int CAPACITY = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   kvt_req_if        req_mon,
   kvt_rsp_if        rsp_mon,
   output int        mismatch_total,
   output int        pending_replies
);
   import kvt_pkg::*;

   typedef struct packed {
      status_type                status;
      logic signed [VALUE_W-1:0] found_value;
      logic [COUNT_W-1:0]        entry_count;
   } table_reply_type;

   logic                      slot_used [CAPACITY];
   logic signed [KEY_W-1:0]   slot_key  [CAPACITY];
   logic signed [VALUE_W-1:0] slot_val  [CAPACITY];
   int unsigned               occupancy;
   table_reply_type           reply_q [$];

   // updates the table for one request and returns the response it should give
   function automatic table_reply_type apply_request(logic [1:0] op,
                                                     logic signed [KEY_W-1:0] key,
                                                     logic signed [VALUE_W-1:0] value);
      table_reply_type r;
      int hit;
      int free_idx;
      hit = -1;
      free_idx = -1;
      // walk downward so both indexes end on the lowest match
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (slot_used[i] && slot_key[i] == key) hit = i;
         if (!slot_used[i]) free_idx = i;
      end
      r.status = STAT_NOT_FOUND;
      r.found_value = '0;
      case (op)
         OP_INSERT: begin
            if (hit >= 0) begin
               r.status = STAT_PRESENT;
            end else if (occupancy >= CAPACITY || free_idx < 0) begin
               r.status = STAT_FULL;
            end else begin
               slot_used[free_idx] = 1'b1;
               slot_key[free_idx] = key;
               slot_val[free_idx] = value;
               occupancy++;
               r.status = STAT_OK;
            end
         end
         OP_LOOKUP: begin
            if (hit >= 0) begin
               r.status = STAT_OK;
               r.found_value = slot_val[hit];
            end
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               r.status = STAT_OK;
               r.found_value = slot_val[hit];
               slot_used[hit] = 1'b0;
               if (occupancy > 0) occupancy--;
            end
         end
         default: begin
         end
      endcase
      r.entry_count = occupancy[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      table_reply_type want;
      int fails;
      fails = 0;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
         occupancy = 0;
         reply_q.delete();
      end else begin
         // responses first: one leaving at this edge belongs to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reply_q.size() == 0) begin
               $display("%0t: response with no request outstanding, status %0d value %0d count %0d",
                        $time, rsp_mon.status, rsp_mon.found_value, rsp_mon.entry_count);
               fails++;
            end else begin
               want = reply_q.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_mon.status);
                  fails++;
               end
               if (rsp_mon.found_value !== want.found_value) begin
                  $display("%0t: found_value mismatch, expected %0d, actual %0d",
                           $time, want.found_value, rsp_mon.found_value);
                  fails++;
               end
               if (rsp_mon.entry_count !== want.entry_count) begin
                  $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                           $time, want.entry_count, rsp_mon.entry_count);
                  fails++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            reply_q.push_back(apply_request(req_mon.opcode, req_mon.lookup_key,
                                            req_mon.new_value));
         end
      end
      mismatch_total <= mismatch_total + fails;
      pending_replies <= reply_q.size();
   end

endmodule

@@ dv/key_value_table_core_test.sv @@
// top of the key_value_table_core testbench: clock, reset, request stimulus and
// response back-pressure; the verdict comes from key_value_table_core_checker
// depends on kvt_pkg, kvt_req_if, kvt_rsp_if and the block itself
module key_value_table_core_test;
   import kvt_pkg::*;

   localparam int CAPACITY = 16;
   localparam int RANDOM_ITEMS = 1350;
   localparam int POOL_SIZE = 24;
   localparam int DRAIN_CYCLES = 2 * (CAPACITY + 2) + 20;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef enum int {
      SINK_STEADY,
      SINK_RANDOM,
      SINK_SLOW,
      SINK_PERIODIC
   } sink_mode_type;

   logic clock;
   logic reset;
   int   mismatch_total;
   int   pending_replies;
   int   cycle_count;
   int   burst_left;

   sink_mode_type sink_mode;
   int            sink_left;

   logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

   kvt_req_if req_bus ();
   kvt_rsp_if rsp_bus ();

   key_value_table_core #(
      .CAPACITY(CAPACITY)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   key_value_table_core_checker #(
      .CAPACITY(CAPACITY)
   ) kv_check (
      .clock(clock),
      .reset(reset),
      .req_mon(req_bus),
      .rsp_mon(rsp_bus),
      .mismatch_total(mismatch_total),
      .pending_replies(pending_replies)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response back-pressure switches between steady, random, slow and periodic modes at random intervals
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         sink_left <= $urandom_range(20, 200);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         SINK_STEADY:   rsp_bus.ready <= 1'b1;
         SINK_RANDOM:   rsp_bus.ready <= $urandom_range(0, 1);
         SINK_SLOW:     rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         SINK_PERIODIC: rsp_bus.ready <= (sink_left % 6 == 0);
         default:       rsp_bus.ready <= 1'b1;
      endcase
   end

   task automatic send_request(input logic [1:0] op, input logic signed [KEY_W-1:0] key,
                               input logic signed [VALUE_W-1:0] value);
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.lookup_key <= key;
      req_bus.new_value <= value;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // ends a burst now and then with an idle gap
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 45);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(0, 11);
      end
   endtask

   initial begin
      logic [1:0]                op;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
      int                        pick;
      bit                        grow;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_INSERT;
      req_bus.lookup_key = '0;
      req_bus.new_value = '0;
      rsp_bus.ready = 1'b0;
      burst_left = 0;
      grow = 1'b0;
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7fff_ffff;
      key_pool[2] = 32'sh0000_0000;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty table, unused opcode, extreme keys and values
      send_request(OP_LOOKUP, 32'sh0000_0000, 32'sh0000_0000);
      pace_sender();
      send_request(OP_REMOVE, 32'sh8000_0000, -32'sd1);
      pace_sender();
      send_request(OP_UNUSED, 32'sh7fff_ffff, 32'sh7fff_ffff);
      pace_sender();
      send_request(OP_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
      pace_sender();
      send_request(OP_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
      pace_sender();
      send_request(OP_INSERT, 32'sh0000_0000, 32'sh0000_0000);
      pace_sender();
      send_request(OP_INSERT, -32'sd1, -32'sd1);
      pace_sender();
      send_request(OP_INSERT, 32'sh7fff_ffff, 32'sh1234_5678);
      pace_sender();
      send_request(OP_LOOKUP, 32'sh8000_0000, 32'sh0000_0000);
      pace_sender();
      // fill to capacity, then overflow and duplicate on a full table
      for (int i = 1; i <= CAPACITY - 4; i++) begin
         send_request(OP_INSERT, i, (i % 2) ? 32'sh5555_5555 : 32'shaaaa_aaaa);
         pace_sender();
      end
      send_request(OP_INSERT, 32'sd100, 32'sd7);
      pace_sender();
      send_request(OP_INSERT, 32'sh0000_0000, 32'sd9);
      pace_sender();
      send_request(OP_REMOVE, -32'sd1, 32'sd0);
      pace_sender();
      send_request(OP_LOOKUP, -32'sd1, 32'sd0);
      pace_sender();
      // refills the hole left by the remove
      send_request(OP_INSERT, 32'sd100, 32'sh0f0f_0f0f);
      pace_sender();
      send_request(OP_UNUSED, 32'sd100, 32'sd0);
      pace_sender();

      // alternate phases that fill the table and drain it, keys mostly from a
      // small pool so that hits, duplicates and full-table rejects keep occurring
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) grow = !grow;
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            op = OP_UNUSED;
         end else if (grow) begin
            op = (pick < 60) ? OP_INSERT : (pick < 80) ? OP_LOOKUP : OP_REMOVE;
         end else begin
            op = (pick < 25) ? OP_INSERT : (pick < 50) ? OP_LOOKUP : OP_REMOVE;
         end
         if ($urandom_range(0, 9) < 7) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else key = $urandom;
         if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
         value = $urandom;
         send_request(op, key, value);
         pace_sender();
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_replies != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && pending_replies == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
